[rtl/bgpq_pkg.sv]
// Shared types, sizes and codes for the busy-gated priority queue dispatcher.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bgpq_pkg;

  localparam int NumOperators = 8;
  localparam int QueueDepth   = 16;
  localparam int TagWidth     = 16;

  localparam int MaskW   = 8;
  localparam int OpW     = 3;
  localparam int OTagW   = 16;
  localparam int IdxW    = (NumOperators > 1) ? $clog2(NumOperators) : 1;
  localparam int PtrW    = $clog2(QueueDepth);
  localparam int CntW    = $clog2(QueueDepth + 1);
  localparam int Entries = NumOperators * QueueDepth;
  localparam int AddrW   = $clog2(Entries);

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [PtrW-1:0]         ptr_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [TagWidth-1:0]     tag_t;
  typedef logic [OTagW-1:0]        otag_t;
  typedef logic [OpW-1:0]          op_t;
  typedef logic [NumOperators-1:0] opvec_t;

  typedef enum logic [0:0] {
    REQ_ARRIVAL = 1'b0,
    REQ_DONE    = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_DISPATCHED = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_IDLE       = 3'd2,
    ST_DROPPED    = 3'd3,
    ST_DONE_IDLE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    Q_NONE = 2'd0,
    Q_PUSH = 2'd1,
    Q_POP  = 2'd2
  } qop_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EVAL = 2'd1,
    S_READ = 2'd2
  } state_e;

  typedef struct packed {
    qop_e op;
    idx_t idx;
    tag_t tag;
  } qcmd_t;

  typedef struct packed {
    opvec_t nonempty;
    opvec_t full;
  } qstat_t;

  // Index of the highest set bit; zero when no bit is set.
  function automatic idx_t highest_index(input opvec_t v);
    idx_t r;
    r = '0;
    for (int k = 0; k < NumOperators; k++) begin
      if (v[k]) begin
        r = idx_t'(k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/busy_gated_priority_queue_dispatcher.sv]
// Top level of the busy-gated strict-priority dispatcher.
// Holds the active-mask register and connects bgpq_ctrl and bgpq_queues; uses bgpq_pkg.
//
// Usage:
//   An item is accepted at a rising edge where start is high and busy is low.
//   An arrival item (req_type 0) is dispatched at once, queued in its
//   operator's FIFO, or dropped when that FIFO is full. A done item (req_type 1)
//   frees the worker and hands it the head of the highest-numbered nonempty
//   queue whose operator is active.
//   Every item gives one result, shown for one cycle with result_strobe_o high.
//   The receiver cannot stall; results must be taken as they appear.
//   Sequence: an accepted item moves the sequencer to S_EVAL, where busy is
//   high, so no new item is taken until it returns to S_IDLE; the result of
//   S_EVAL is registered onto the outputs. A done item that pops a queue also
//   passes S_READ: the single port of the shared item store is read first.
//   The user writes the active mask on the cfg channel (always ready) while
//   idle; the block does not enforce this. A mask change dispatches nothing by itself.
//   Reset clears the mask, the busy flag and all queue pointers and counts.
`default_nettype none

module busy_gated_priority_queue_dispatcher (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire                           req_type_i,
  input  wire  [bgpq_pkg::OpW-1:0]      op_index_i,
  input  wire                           is_endpoint_i,
  input  wire  [bgpq_pkg::OTagW-1:0]    item_tag_i,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [bgpq_pkg::MaskW-1:0]    cfg_wdata_i,
  output logic                          result_strobe_o,
  output logic [2:0]                    status_o,
  output logic [bgpq_pkg::OpW-1:0]      dispatch_op_o,
  output logic [bgpq_pkg::OTagW-1:0]    dispatch_tag_o,
  output logic                          worker_busy_o
);

  logic [bgpq_pkg::MaskW-1:0] mask_q;
  bgpq_pkg::qcmd_t            qcmd;
  bgpq_pkg::qstat_t           qstat;
  bgpq_pkg::tag_t             rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= cfg_wdata_i;
    end
  end

  bgpq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .req_type_i    (req_type_i),
    .op_index_i    (op_index_i),
    .is_endpoint_i (is_endpoint_i),
    .item_tag_i    (item_tag_i),
    .mask_i        (mask_q),
    .qstat_i       (qstat),
    .rdata_i       (rdata),
    .qcmd_o        (qcmd),
    .strobe_o      (result_strobe_o),
    .status_o      (status_o),
    .dop_o         (dispatch_op_o),
    .dtag_o        (dispatch_tag_o),
    .wbusy_o       (worker_busy_o)
  );

  bgpq_queues u_queues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qcmd_i  (qcmd),
    .qstat_o (qstat),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

[rtl/bgpq_queues.sv]
// Per-operator FIFO queues: head, tail and count registers plus the shared item store.
// One push or pop per cycle through a single pointer-advance unit. Uses bgpq_pkg.
`default_nettype none

module bgpq_queues (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  bgpq_pkg::qcmd_t   qcmd_i,
  output bgpq_pkg::qstat_t  qstat_o,
  output bgpq_pkg::tag_t    rdata_o
);

  bgpq_pkg::ptr_t  head_q  [bgpq_pkg::NumOperators];
  bgpq_pkg::ptr_t  tail_q  [bgpq_pkg::NumOperators];
  bgpq_pkg::cnt_t  count_q [bgpq_pkg::NumOperators];
  bgpq_pkg::tag_t  mem     [bgpq_pkg::Entries];
  bgpq_pkg::tag_t  rdata_q;

  bgpq_pkg::ptr_t  ptr_sel;
  bgpq_pkg::ptr_t  ptr_nxt;
  bgpq_pkg::addr_t addr;

  // The pointer being advanced is the tail on a push and the head on a pop.
  always_comb begin
    ptr_sel = (qcmd_i.op == bgpq_pkg::Q_PUSH) ? tail_q[qcmd_i.idx] : head_q[qcmd_i.idx];
    ptr_nxt = (ptr_sel == bgpq_pkg::ptr_t'(bgpq_pkg::QueueDepth - 1))
              ? '0 : ptr_sel + bgpq_pkg::ptr_t'(1);
    addr    = bgpq_pkg::addr_t'(int'(qcmd_i.idx) * bgpq_pkg::QueueDepth + int'(ptr_sel));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bgpq_pkg::NumOperators; k++) begin
        head_q[k]  <= '0;
        tail_q[k]  <= '0;
        count_q[k] <= '0;
      end
    end else begin
      case (qcmd_i.op)
        bgpq_pkg::Q_PUSH: begin
          tail_q[qcmd_i.idx]  <= ptr_nxt;
          count_q[qcmd_i.idx] <= count_q[qcmd_i.idx] + bgpq_pkg::cnt_t'(1);
        end
        bgpq_pkg::Q_POP: begin
          head_q[qcmd_i.idx]  <= ptr_nxt;
          count_q[qcmd_i.idx] <= count_q[qcmd_i.idx] - bgpq_pkg::cnt_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (qcmd_i.op == bgpq_pkg::Q_PUSH) begin
      mem[addr] <= qcmd_i.tag;
    end
    if (qcmd_i.op == bgpq_pkg::Q_POP) begin
      rdata_q <= mem[addr];
    end
  end

  for (genvar k = 0; k < bgpq_pkg::NumOperators; k++) begin : g_stat
    assign qstat_o.full[k]     = (count_q[k] == bgpq_pkg::cnt_t'(bgpq_pkg::QueueDepth));
    assign qstat_o.nonempty[k] = (count_q[k] != '0);
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bgpq_ctrl.sv]
// Sequencer of the dispatcher: decides dispatch, queue or drop, selects the
// highest eligible queue and registers the result. Uses bgpq_pkg.
`default_nettype none

module bgpq_ctrl (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire                           req_type_i,
  input  wire  [bgpq_pkg::OpW-1:0]      op_index_i,
  input  wire                           is_endpoint_i,
  input  wire  [bgpq_pkg::OTagW-1:0]    item_tag_i,
  input  wire  [bgpq_pkg::MaskW-1:0]    mask_i,
  input  bgpq_pkg::qstat_t              qstat_i,
  input  bgpq_pkg::tag_t                rdata_i,
  output bgpq_pkg::qcmd_t               qcmd_o,
  output logic                          strobe_o,
  output logic [2:0]                    status_o,
  output logic [bgpq_pkg::OpW-1:0]      dop_o,
  output logic [bgpq_pkg::OTagW-1:0]    dtag_o,
  output logic                          wbusy_o
);

  bgpq_pkg::state_e  state_q, state_d;
  bgpq_pkg::req_e    req_q;
  bgpq_pkg::op_t     op_q;
  logic              ep_q;
  bgpq_pkg::otag_t   tag_q;
  logic              busy_flag_q, busy_flag_d;
  bgpq_pkg::idx_t    popq_q, popq_d;

  logic              strobe_q;
  bgpq_pkg::status_e status_q;
  bgpq_pkg::op_t     dop_q;
  bgpq_pkg::otag_t   dtag_q;
  logic              wbusy_q;

  logic              res_valid;
  bgpq_pkg::status_e res_status;
  bgpq_pkg::op_t     res_op;
  bgpq_pkg::otag_t   res_tag;

  bgpq_pkg::opvec_t  eligible;
  bgpq_pkg::idx_t    best_q;
  bgpq_pkg::idx_t    op_idx;
  logic              op_in_range;

  // Operators past the mask width are never active.
  for (genvar k = 0; k < bgpq_pkg::NumOperators; k++) begin : g_elig
    if (k < bgpq_pkg::MaskW) begin : g_masked
      assign eligible[k] = qstat_i.nonempty[k] & mask_i[k];
    end else begin : g_never
      assign eligible[k] = 1'b0;
    end
  end

  assign best_q      = bgpq_pkg::highest_index(eligible);
  assign op_idx      = bgpq_pkg::idx_t'(op_q);
  assign op_in_range = (int'(op_q) < bgpq_pkg::NumOperators);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bgpq_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = bgpq_pkg::S_EVAL;
        end
      end
      bgpq_pkg::S_EVAL: begin
        if (req_q == bgpq_pkg::REQ_DONE && busy_flag_q && (|eligible)) begin
          state_d = bgpq_pkg::S_READ;
        end else begin
          state_d = bgpq_pkg::S_IDLE;
        end
      end
      bgpq_pkg::S_READ: state_d = bgpq_pkg::S_IDLE;
      default:          state_d = bgpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy_flag_d = busy_flag_q;
    popq_d      = popq_q;
    res_valid   = 1'b0;
    res_status  = bgpq_pkg::ST_IDLE;
    res_op      = '0;
    res_tag     = '0;
    qcmd_o.op   = bgpq_pkg::Q_NONE;
    qcmd_o.idx  = op_idx;
    qcmd_o.tag  = bgpq_pkg::tag_t'(tag_q);
    case (state_q)
      bgpq_pkg::S_EVAL: begin
        res_valid = 1'b1;
        if (req_q == bgpq_pkg::REQ_ARRIVAL) begin
          if (!op_in_range) begin
            res_status = bgpq_pkg::ST_DROPPED;
          end else if (!busy_flag_q && (mask_i[op_q] || ep_q)) begin
            busy_flag_d = 1'b1;
            res_status  = bgpq_pkg::ST_DISPATCHED;
            res_op      = op_q;
            res_tag     = bgpq_pkg::otag_t'(bgpq_pkg::tag_t'(tag_q));
          end else if (qstat_i.full[op_idx]) begin
            res_status = bgpq_pkg::ST_DROPPED;
          end else begin
            qcmd_o.op  = bgpq_pkg::Q_PUSH;
            res_status = bgpq_pkg::ST_QUEUED;
          end
        end else if (!busy_flag_q) begin
          res_status = bgpq_pkg::ST_DONE_IDLE;
        end else if (!(|eligible)) begin
          busy_flag_d = 1'b0;
          res_status  = bgpq_pkg::ST_IDLE;
        end else begin
          // The popped tag arrives from the store next cycle; report it then.
          res_valid  = 1'b0;
          qcmd_o.op  = bgpq_pkg::Q_POP;
          qcmd_o.idx = best_q;
          popq_d     = best_q;
        end
      end
      bgpq_pkg::S_READ: begin
        res_valid  = 1'b1;
        res_status = bgpq_pkg::ST_DISPATCHED;
        res_op     = bgpq_pkg::op_t'(popq_q);
        res_tag    = bgpq_pkg::otag_t'(rdata_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgpq_pkg::S_IDLE;
      busy_flag_q <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_flag_q <= busy_flag_d;
      strobe_q    <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    popq_q <= popq_d;
    if (state_q == bgpq_pkg::S_IDLE && start_i) begin
      req_q <= bgpq_pkg::req_e'(req_type_i);
      op_q  <= op_index_i;
      ep_q  <= is_endpoint_i;
      tag_q <= item_tag_i;
    end
    if (res_valid) begin
      status_q <= res_status;
      dop_q    <= res_op;
      dtag_q   <= res_tag;
      wbusy_q  <= busy_flag_d;
    end
  end

  assign busy_o   = (state_q != bgpq_pkg::S_IDLE);
  assign strobe_o = strobe_q;
  assign status_o = status_q;
  assign dop_o    = dop_q;
  assign dtag_o   = dtag_q;
  assign wbusy_o  = wbusy_q;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcmd_o.op == bgpq_pkg::Q_PUSH) |-> !qstat_i.full[qcmd_o.idx])
    else $error("push issued to a full queue");

  a_pop_eligible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcmd_o.op == bgpq_pkg::Q_POP) |-> (eligible[qcmd_o.idx] && busy_flag_q))
    else $error("pop issued to an ineligible queue");

  a_read_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgpq_pkg::S_READ) |=> (strobe_q && status_q == bgpq_pkg::ST_DISPATCHED))
    else $error("queued dispatch not reported");

  a_dispatch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && status_q == bgpq_pkg::ST_DISPATCHED) |-> (wbusy_q && busy_flag_q))
    else $error("dispatch reported with idle worker");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == bgpq_pkg::S_EVAL))
    else $error("accepted item not evaluated");

endmodule

`default_nettype wire
